// ----- rtl/odl_pkg.sv -----
package odl_pkg;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_W    = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int ACTION_W   = 3;
	localparam int INDEX_W    = 8;
	localparam int DATA_W     = 32;
	localparam int STATUS_W   = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_ORDER = 3'd2,
		ACT_REMOVE    = 3'd3,
		ACT_READ      = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_RESP = 2'd2
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ----- rtl/odl_ctrl.sv -----
module odl_ctrl
	import odl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_n = S_EXEC;
			end
			S_EXEC: begin
				state_n = S_RESP;
			end
			S_RESP: begin
				if (start) state_n = S_EXEC;
				else       state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy     = 1'b0;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			S_RESP: begin
				done     = 1'b1;
				cmd.load = start;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	a_exec_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("execute state lasted more than one cycle");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_EXEC)
		else $error("result strobe without a preceding execute cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && cmd.exec))
		else $error("accepted transfer did not enter execute");

endmodule

// ----- rtl/odl_dpath.sv -----
module odl_dpath
	import odl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [DATA_W-1:0]   value,
	input  logic [INDEX_W-1:0]         index,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   read_value,
	output logic [COUNT_W-1:0]         entry_count
);

	logic [ACTION_W-1:0]            action_q;
	logic signed [DATA_W-1:0]       value_q;
	logic [INDEX_W-1:0]             index_q;
	logic signed [VALUE_BITS-1:0]   entries_q [DEPTH];
	logic [COUNT_W-1:0]             count_q;
	status_t                        status_q;
	logic signed [DATA_W-1:0]       read_value_q;

	logic signed [63:0]             val_ext;
	logic signed [VALUE_BITS-1:0]   val_w;
	logic signed [VALUE_BITS-1:0]   prev_e [DEPTH];
	logic signed [VALUE_BITS-1:0]   next_e [DEPTH];
	logic signed [VALUE_BITS-1:0]   entries_n [DEPTH];
	logic [DEPTH-1:0]               live;
	logic [DEPTH-1:0]               ge;
	logic                           last_le;
	logic signed [VALUE_BITS-1:0]   sel_e;
	logic signed [63:0]             sel_ext;
	logic [IDX_W-1:0]               idx_lo;
	logic [COUNT_W-1:0]             ord_pos;
	logic [COUNT_W-1:0]             ins_pos;
	logic                           do_ins;
	logic                           do_rem;
	logic                           do_sel;
	status_t                        status_n;
	logic [COUNT_W-1:0]             count_n;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			value_q  <= value;
			index_q  <= index;
		end
	end

	// sign-extend then wrap to the storage width
	assign val_ext = 64'(value_q);
	assign val_w   = val_ext[VALUE_BITS-1:0];
	assign idx_lo  = index_q[IDX_W-1:0];

	// per-cell compares and neighbor taps
	always_comb begin
		live    = '0;
		ge      = '0;
		last_le = 1'b0;
		sel_e   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			live[i] = COUNT_W'(i) < count_q;
			ge[i]   = entries_q[i] >= val_w;
			if ((COUNT_W'(i) + COUNT_W'(1)) == count_q && val_w >= entries_q[i])
				last_le = 1'b1;
			if (IDX_W'(i) == idx_lo)
				sel_e = sel_e | entries_q[i];
		end
		prev_e[0] = '0;
		for (int i = 1; i < DEPTH; i++) prev_e[i] = entries_q[i-1];
		next_e[DEPTH-1] = '0;
		for (int i = 0; i < DEPTH - 1; i++) next_e[i] = entries_q[i+1];
	end

	// ordered insert position
	always_comb begin
		ord_pos = count_q;
		if (count_q == '0 || val_w <= entries_q[0]) begin
			ord_pos = '0;
		end else if (!last_le) begin
			for (int i = DEPTH - 1; i >= 0; i--) begin
				if (live[i] && ge[i]) ord_pos = COUNT_W'(i);
			end
		end
	end

	// action decode
	always_comb begin
		status_n = ST_OK;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		do_sel   = 1'b0;
		ins_pos  = '0;
		case (action_q)
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_ORDER: begin
				if (count_q >= COUNT_W'(DEPTH)) begin
					status_n = ST_FULL;
				end else begin
					do_ins = 1'b1;
					if (action_q == ACT_INS_FRONT)     ins_pos = '0;
					else if (action_q == ACT_INS_BACK) ins_pos = count_q;
					else                               ins_pos = ord_pos;
				end
			end
			ACT_REMOVE, ACT_READ: begin
				if (count_q == '0) begin
					status_n = ST_EMPTY;
				end else if (9'(index_q) >= 9'(count_q)) begin
					status_n = ST_RANGE;
				end else begin
					do_sel = 1'b1;
					do_rem = (action_q == ACT_REMOVE);
				end
			end
			default: begin
				status_n = ST_OK;
			end
		endcase
	end

	// shift row
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			entries_n[i] = entries_q[i];
			if (do_ins) begin
				if (COUNT_W'(i) == ins_pos)
					entries_n[i] = val_w;
				else if (COUNT_W'(i) > ins_pos && COUNT_W'(i) <= count_q)
					entries_n[i] = prev_e[i];
			end else if (do_rem) begin
				if (COUNT_W'(i) >= COUNT_W'(idx_lo) &&
				    (COUNT_W'(i) + COUNT_W'(1)) < count_q)
					entries_n[i] = next_e[i];
			end
		end
		count_n = count_q;
		if (do_ins)      count_n = count_q + COUNT_W'(1);
		else if (do_rem) count_n = count_q - COUNT_W'(1);
	end

	assign sel_ext = 64'(sel_e);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			entries_q    <= entries_n;
			status_q     <= status_n;
			read_value_q <= do_sel ? sel_ext[DATA_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_n;
		end
	end

	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count beyond capacity");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && status_n == ST_FULL) |=> $stable(count_q))
		else $error("count changed on a full insert");

	a_count_only_on_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("count changed outside execute");

endmodule

// ----- rtl/ordered_deque_list.sv -----
// Ordered deque list: a bounded sequence of signed entries held in a row of
// shifting cells, front at position 0.
//
// Command channel: drive action, value and index with start high; the
// transfer happens on the rising edge where start is high and busy is low.
// Actions: insert front, insert back, ordered insert, remove at index,
// read at index. Unused action codes leave the list alone and report ok.
//
// Result channel: done is high for exactly one cycle, the cycle right after
// the execute cycle. status, read_value and entry_count are valid in that
// cycle. The receiver cannot stall; it must take the result when done fires.
//
// busy is high only during the single execute cycle, in which the full
// compare/priority/shift over all cells completes; a new command may be taken
// in the same cycle a result is shown.
//
// Reset (arst_n low, asynchronous): the list empties and the controller
// idles. Entry contents are not cleared; only live positions are ever read.
module ordered_deque_list
	import odl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [DATA_W-1:0]   value,
	input  logic [INDEX_W-1:0]         index,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [DATA_W-1:0]   read_value,
	output logic [COUNT_W-1:0]         entry_count
);

	dp_cmd_t cmd;

	// sequencer: idle / execute / respond
	odl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// cell row, compare array and result registers
	odl_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.action      (action),
		.value       (value),
		.index       (index),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

endmodule
